### rtl/csplit_pkg.sv
package csplit_pkg;

	// fixed formats of the segment fields
	localparam int COORD_W = 32;
	localparam int T_FRAC = 16;
	localparam logic [T_FRAC-1:0] T_MIN = {{(T_FRAC-1){1'b0}}, 1'b1};
	localparam logic [T_FRAC-1:0] T_MAX = {T_FRAC{1'b1}};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [T_FRAC-1:0] frac_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		coord_t start_anchor_x;
		coord_t start_anchor_y;
		coord_t start_handle_x;
		coord_t start_handle_y;
		logic start_has_handle;
		coord_t end_handle_x;
		coord_t end_handle_y;
		logic end_has_handle;
		coord_t end_anchor_x;
		coord_t end_anchor_y;
		logic [T_FRAC:0] split_t;
	} in_item_t;

	typedef struct packed {
		coord_t mid_anchor_x;
		coord_t mid_anchor_y;
		coord_t left_out_x;
		coord_t left_out_y;
		coord_t mid_in_x;
		coord_t mid_in_y;
		coord_t mid_out_x;
		coord_t mid_out_y;
		coord_t right_in_x;
		coord_t right_in_y;
		logic segment_was_cubic;
	} out_item_t;

endpackage

### rtl/cubic_segment_split.sv
// cubic_segment_split: splits one path segment at a fraction by de casteljau
// subdivision.
// the seg channel (valid/ready) carries one segment per item: two anchors,
// two optional handles with presence flags and the split fraction. the res
// channel (valid/ready) returns one item per segment: the inserted anchor
// and, for a cubic segment, the four new handles.
// a segment with neither handle present is a line; its handle fields are
// zero and segment_was_cubic is low.
// one segment is taken in every cycle unless the pipeline is full and
// stalled by the receiver; the seven-stage pipeline has three
// interpolation levels (multiply stage plus add stage each) behind one
// select stage, the select stage being loaded at the accepting edge.
// reset clears only the stage valid bits; the data registers are not reset.
// when the receiver stalls, each stage holds only if the stage after it is
// full and held, so bubbles close up and seg_ready stays high until all
// seven stages are occupied.
module cubic_segment_split (
	input logic clk,
	input logic arst_n,
	input logic seg_valid,
	output logic seg_ready,
	input csplit_pkg::in_item_t seg,
	output logic res_valid,
	input logic res_ready,
	output csplit_pkg::out_item_t res
);

	logic [7:1] v;
	logic [7:1] en;

	logic cub_d;
	csplit_pkg::frac_t t_d;
	csplit_pkg::point_t p0_d, p1_d, p2_d, p3_d;

	csplit_pkg::point_t p0_s1, p1_s1, p2_s1, p3_s1;
	csplit_pkg::frac_t t_s1, t_s2, t_s3, t_s4, t_s5;
	logic cub_s1, cub_s2, cub_s3, cub_s4, cub_s5, cub_s6, cub_s7;

	csplit_pkg::point_t p01_s3, p12_s3, p23_s3;
	csplit_pkg::point_t p01_s4, p12_s4, p23_s4;
	csplit_pkg::point_t p01_s5, p12_s5, p23_s5;
	csplit_pkg::point_t p01_s6, p12_s6, p23_s6;
	csplit_pkg::point_t p01_s7, p12_s7, p23_s7;
	csplit_pkg::point_t p012_s5, p123_s5;
	csplit_pkg::point_t p012_s6, p123_s6;
	csplit_pkg::point_t p012_s7, p123_s7;
	csplit_pkg::point_t pm_s7;

	// stage advance: a stage moves when empty or when the next one moves
	assign en[7] = !v[7] || res_ready;
	assign en[6] = !v[6] || en[7];
	assign en[5] = !v[5] || en[6];
	assign en[4] = !v[4] || en[5];
	assign en[3] = !v[3] || en[4];
	assign en[2] = !v[2] || en[3];
	assign en[1] = !v[1] || en[2];
	assign seg_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= seg_valid;
			if (en[2]) v[2] <= v[1];
			if (en[3]) v[3] <= v[2];
			if (en[4]) v[4] <= v[3];
			if (en[5]) v[5] <= v[4];
			if (en[6]) v[6] <= v[5];
			if (en[7]) v[7] <= v[6];
		end
	end

	// clamp the fraction and stand in anchors for missing handles
	always_comb begin
		if (seg.split_t[csplit_pkg::T_FRAC]) begin
			t_d = csplit_pkg::T_MAX;
		end else if (seg.split_t[csplit_pkg::T_FRAC-1:0] == '0) begin
			t_d = csplit_pkg::T_MIN;
		end else begin
			t_d = seg.split_t[csplit_pkg::T_FRAC-1:0];
		end
		cub_d = seg.start_has_handle || seg.end_has_handle;
		p0_d.x = seg.start_anchor_x;
		p0_d.y = seg.start_anchor_y;
		p3_d.x = seg.end_anchor_x;
		p3_d.y = seg.end_anchor_y;
		p1_d = p0_d;
		p2_d = p3_d;
		if (seg.start_has_handle) begin
			p1_d.x = seg.start_handle_x;
			p1_d.y = seg.start_handle_y;
		end
		if (seg.end_has_handle) begin
			p2_d.x = seg.end_handle_x;
			p2_d.y = seg.end_handle_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p0_s1 <= p0_d;
			p1_s1 <= p1_d;
			p2_s1 <= p2_d;
			p3_s1 <= p3_d;
			t_s1 <= t_d;
			cub_s1 <= cub_d;
		end
	end

	// first level; for a line p12 is the wanted anchor
	csplit_lerp u_l01 (.clk(clk), .en_mul(en[2]), .en_add(en[3]),
		.a(p0_s1), .b(p1_s1), .t(t_s1), .y(p01_s3));
	csplit_lerp u_l12 (.clk(clk), .en_mul(en[2]), .en_add(en[3]),
		.a(p1_s1), .b(p2_s1), .t(t_s1), .y(p12_s3));
	csplit_lerp u_l23 (.clk(clk), .en_mul(en[2]), .en_add(en[3]),
		.a(p2_s1), .b(p3_s1), .t(t_s1), .y(p23_s3));

	// second level
	csplit_lerp u_l012 (.clk(clk), .en_mul(en[4]), .en_add(en[5]),
		.a(p01_s3), .b(p12_s3), .t(t_s3), .y(p012_s5));
	csplit_lerp u_l123 (.clk(clk), .en_mul(en[4]), .en_add(en[5]),
		.a(p12_s3), .b(p23_s3), .t(t_s3), .y(p123_s5));

	// third level gives the split anchor
	csplit_lerp u_lmid (.clk(clk), .en_mul(en[6]), .en_add(en[7]),
		.a(p012_s5), .b(p123_s5), .t(t_s5), .y(pm_s7));

	// side data traveling with the interpolation levels
	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s2 <= t_s1;
			cub_s2 <= cub_s1;
		end
		if (en[3]) begin
			t_s3 <= t_s2;
			cub_s3 <= cub_s2;
		end
		if (en[4]) begin
			t_s4 <= t_s3;
			cub_s4 <= cub_s3;
			p01_s4 <= p01_s3;
			p12_s4 <= p12_s3;
			p23_s4 <= p23_s3;
		end
		if (en[5]) begin
			t_s5 <= t_s4;
			cub_s5 <= cub_s4;
			p01_s5 <= p01_s4;
			p12_s5 <= p12_s4;
			p23_s5 <= p23_s4;
		end
		if (en[6]) begin
			cub_s6 <= cub_s5;
			p01_s6 <= p01_s5;
			p12_s6 <= p12_s5;
			p23_s6 <= p23_s5;
			p012_s6 <= p012_s5;
			p123_s6 <= p123_s5;
		end
		if (en[7]) begin
			cub_s7 <= cub_s6;
			p01_s7 <= p01_s6;
			p12_s7 <= p12_s6;
			p23_s7 <= p23_s6;
			p012_s7 <= p012_s6;
			p123_s7 <= p123_s6;
		end
	end

	// result item from the last stage; handles zero for a line
	assign res_valid = v[7];
	always_comb begin
		res = '0;
		res.segment_was_cubic = cub_s7;
		if (cub_s7) begin
			res.mid_anchor_x = pm_s7.x;
			res.mid_anchor_y = pm_s7.y;
			res.left_out_x = p01_s7.x;
			res.left_out_y = p01_s7.y;
			res.mid_in_x = p012_s7.x;
			res.mid_in_y = p012_s7.y;
			res.mid_out_x = p123_s7.x;
			res.mid_out_y = p123_s7.y;
			res.right_in_x = p23_s7.x;
			res.right_in_y = p23_s7.y;
		end else begin
			res.mid_anchor_x = p12_s7.x;
			res.mid_anchor_y = p12_s7.y;
		end
	end

	// an accepted item always lands in the first stage
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_ready |=> v[1])
		else $error("accepted item did not enter the first stage");

	// a held result keeps its payload
	a_hold_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// a line result carries no handles
	a_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.segment_was_cubic |->
			res.left_out_x == '0 && res.left_out_y == '0 &&
			res.mid_in_x == '0 && res.mid_in_y == '0 &&
			res.mid_out_x == '0 && res.mid_out_y == '0 &&
			res.right_in_x == '0 && res.right_in_y == '0)
		else $error("line result has nonzero handles");

	// input stalls only when every stage is full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_ready |-> v == '1 && !res_ready)
		else $error("input stalled with a free stage");

endmodule

### rtl/csplit_lerp.sv
module csplit_lerp (
	input logic clk,
	input logic en_mul,
	input logic en_add,
	input csplit_pkg::point_t a,
	input csplit_pkg::point_t b,
	input csplit_pkg::frac_t t,
	output csplit_pkg::point_t y
);

	localparam int CW = csplit_pkg::COORD_W;
	localparam int TF = csplit_pkg::T_FRAC;
	localparam int DW = CW + 1;
	localparam int PW = DW + TF + 1;
	localparam int SW = PW - TF;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [TF:0] ts;
	logic signed [PW-1:0] prodx_d;
	logic signed [PW-1:0] prody_d;
	logic signed [PW-1:0] prodx_s1;
	logic signed [PW-1:0] prody_s1;
	csplit_pkg::point_t base_s1;
	logic [SW-1:0] sumx;
	logic [SW-1:0] sumy;

	// difference times fraction, registered
	assign ts = $signed({1'b0, t});
	assign dx = $signed({b.x[CW-1], b.x}) - $signed({a.x[CW-1], a.x});
	assign dy = $signed({b.y[CW-1], b.y}) - $signed({a.y[CW-1], a.y});
	assign prodx_d = dx * ts;
	assign prody_d = dy * ts;

	always_ff @(posedge clk) begin
		if (en_mul) begin
			prodx_s1 <= prodx_d;
			prody_s1 <= prody_d;
			base_s1 <= a;
		end
	end

	// floor of the scaled product added to the start point; stays in range
	assign sumx = {{(SW-CW){base_s1.x[CW-1]}}, base_s1.x} + prodx_s1[PW-1:TF];
	assign sumy = {{(SW-CW){base_s1.y[CW-1]}}, base_s1.y} + prody_s1[PW-1:TF];

	always_ff @(posedge clk) begin
		if (en_add) begin
			y.x <= sumx[CW-1:0];
			y.y <= sumy[CW-1:0];
		end
	end

endmodule
